@@ rtl/battery_median_gauge_defines.svh @@
// ----------------------------------------------------------------------------
// battery_median_gauge_defines.svh
// Assertion macros used by the battery_median_gauge module.
// ----------------------------------------------------------------------------
`ifndef BATTERY_MEDIAN_GAUGE_DEFINES_SVH
`define BATTERY_MEDIAN_GAUGE_DEFINES_SVH

// check cons in the same cycle as ante
`define BMG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define BMG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bmg_pkg.sv @@
// ----------------------------------------------------------------------------
// bmg_pkg
// Types and constants of the battery median gauge.
// ----------------------------------------------------------------------------
`default_nettype none

package bmg_pkg;

	localparam int SAMPLE_W = 12;
	localparam int LEVEL_W  = 7;
	localparam int QUOT_W   = 7;
	localparam int PROD_W   = 19;

	localparam logic [SAMPLE_W-1:0] LOW_RESET  = 12'd1800;
	localparam logic [SAMPLE_W-1:0] HIGH_RESET = 12'd2360;
	localparam logic [LEVEL_W-1:0]  LEVEL_FULL = 7'd100;
	localparam logic [LEVEL_W-1:0]  LEVEL_NONE = 7'd0;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic REG_LOW  = 1'b0;
	localparam logic REG_HIGH = 1'b1;

	typedef struct packed {
		logic                command;
		logic [SAMPLE_W-1:0] sample;
		logic                charging;
	} bmg_in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]  level_percent;
		logic                charge_flag;
		logic [SAMPLE_W-1:0] median_reading;
	} bmg_out_t;

	typedef struct packed {
		logic                start;
		logic [PROD_W-1:0]   dividend;
		logic [SAMPLE_W-1:0] divisor;
	} bmg_div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quotient;
	} bmg_div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/bmg_window.sv @@
// ----------------------------------------------------------------------------
// bmg_window
// Sample window memory, one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmg_window
	import bmg_pkg::*;
#(
	parameter int WINDOW = 20,
	parameter int AW     = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                we,
	input  wire logic [AW-1:0]       waddr,
	input  wire logic [SAMPLE_W-1:0] wdata,
	input  wire logic [AW-1:0]       raddr,
	output      logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [WINDOW];
	logic [WINDOW-1:0]   valid_q;
	logic [SAMPLE_W-1:0] rdata_q;
	logic                rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rvalid_q <= valid_q[raddr];
		end
	end

	// never-written slots read as zero
	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

@@ rtl/bmg_divider.sv @@
// ----------------------------------------------------------------------------
// bmg_divider
// Restoring divider, one quotient bit per cycle, for quotients below 128.
// ----------------------------------------------------------------------------
`default_nettype none

module bmg_divider
	import bmg_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire bmg_div_req_t req,
	output      bmg_div_rsp_t rsp
);

	localparam int SW = $clog2(QUOT_W);
	localparam logic [SW-1:0] TOP_STEP = SW'(QUOT_W - 1);

	logic [PROD_W-1:0] rem_q;
	logic [QUOT_W-1:0] quot_q;
	logic [SW-1:0]     step_q;
	logic              busy_q;
	logic              done_q;
	logic [PROD_W-1:0] shifted;
	logic              fits;

	assign shifted = PROD_W'(req.divisor) << step_q;
	assign fits    = rem_q >= shifted;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			quot_q <= '0;
		end else if (busy_q && fits) begin
			rem_q          <= rem_q - shifted;
			quot_q[step_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= TOP_STEP;
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

`default_nettype wire

@@ rtl/battery_median_gauge.sv @@
// ----------------------------------------------------------------------------
// battery_median_gauge
// Battery level gauge: running upper median over a sample window, mapped
// linearly to 0..100 percent.
// ----------------------------------------------------------------------------
// A sample beat (command 0) writes the oldest window slot; the gauge is
// ready again on the next cycle. A read beat (command 1) walks the window
// by rank counting through the one read port of the window memory: up to
// WINDOW candidates are tried in turn, each fetched, latched and compared
// with every slot in a scan, then come the range checks, the bit-serial
// divider when the median lies strictly inside the range, and the load of
// the result into the output register. in_stall stays high until that load
// is done. A finished result waits in the output register while sample
// beats are still taken. Slots never written since reset count as zero
// readings.
`default_nettype none

`include "battery_median_gauge_defines.svh"

module battery_median_gauge
	import bmg_pkg::*;
#(
	parameter int WINDOW = 20
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [SAMPLE_W-1:0] cfg_data,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire bmg_in_t             in_data,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      bmg_out_t            out_data
);

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [CW-1:0] RANK     = CW'(WINDOW / 2);
	localparam logic [CW-1:0] WIN_SIZE = CW'(WINDOW);
	localparam logic [AW-1:0] LAST     = AW'(WINDOW - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_LATCH = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_MAP   = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]          state_q;
	logic [SAMPLE_W-1:0] low_q;
	logic [SAMPLE_W-1:0] high_q;
	logic [AW-1:0]       slot_q;
	logic [AW-1:0]       cand_idx_q;
	logic [CW-1:0]       scan_q;
	logic                pend_q;
	logic [CW-1:0]       below_q;
	logic [CW-1:0]       at_below_q;
	logic [SAMPLE_W-1:0] cand_q;
	logic [SAMPLE_W-1:0] median_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                chg_q;
	logic                out_valid_q;
	bmg_out_t            out_q;

	logic                in_accept;
	logic                win_we;
	logic [AW-1:0]       raddr;
	logic [SAMPLE_W-1:0] rdata;
	logic                issue;
	logic                found;
	logic                out_free;
	logic [SAMPLE_W-1:0] span;
	logic [SAMPLE_W-1:0] diff;
	bmg_div_req_t        div_req;
	bmg_div_rsp_t        div_rsp;

	assign in_stall  = state_q != ST_IDLE;
	assign in_accept = in_valid && !in_stall;
	assign win_we    = in_accept && in_data.command == CMD_SAMPLE;
	assign issue     = state_q == ST_SCAN && scan_q != WIN_SIZE;
	assign raddr     = (state_q == ST_FETCH) ? cand_idx_q : scan_q[AW-1:0];
	assign found     = below_q <= RANK && RANK < at_below_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign span      = high_q - low_q;
	assign diff      = median_q - low_q;

	assign div_req.start    = state_q == ST_MAP && high_q > low_q &&
	                          median_q > low_q && median_q < high_q;
	assign div_req.dividend = PROD_W'(diff) * PROD_W'(LEVEL_FULL);
	assign div_req.divisor  = span;

	bmg_window #(
		.WINDOW (WINDOW),
		.AW     (AW)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (win_we),
		.waddr  (slot_q),
		.wdata  (in_data.sample),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	bmg_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW:  low_q  <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				default:  low_q  <= low_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			chg_q <= in_data.charging;
		end
		if (state_q == ST_LATCH) begin
			cand_q <= rdata;
		end
		if (state_q == ST_CHECK) begin
			median_q <= found ? cand_q : '0;
		end
		if (state_q == ST_MAP) begin
			if (high_q <= low_q) begin
				level_q <= (median_q < high_q) ? LEVEL_NONE : LEVEL_FULL;
			end else if (median_q <= low_q) begin
				level_q <= LEVEL_NONE;
			end else begin
				level_q <= LEVEL_FULL;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			level_q <= LEVEL_W'(div_rsp.quotient);
		end
		if (state_q == ST_OUT && out_free) begin
			out_q.level_percent  <= level_q;
			out_q.charge_flag    <= chg_q;
			out_q.median_reading <= median_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			cand_idx_q  <= '0;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			below_q     <= '0;
			at_below_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (win_we) begin
						slot_q <= (slot_q == LAST) ? '0 : slot_q + 1'b1;
					end
					if (in_accept && in_data.command == CMD_READ) begin
						cand_idx_q <= '0;
						state_q    <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LATCH;
				end
				ST_LATCH: begin
					scan_q     <= '0;
					pend_q     <= 1'b0;
					below_q    <= '0;
					at_below_q <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (pend_q) begin
						below_q    <= below_q + CW'(rdata < cand_q);
						at_below_q <= at_below_q + CW'(rdata <= cand_q);
						if (!issue) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (found || cand_idx_q == LAST) begin
						state_q <= ST_MAP;
					end else begin
						cand_idx_q <= cand_idx_q + 1'b1;
						state_q    <= ST_FETCH;
					end
				end
				ST_MAP: begin
					state_q <= div_req.start ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BMG_ASSERT_NEXT(a_out_hold, state_q == ST_OUT && out_valid_q && out_stall, state_q == ST_OUT, "result overwrote a waiting beat")
	`BMG_ASSERT_NOW(a_div_owner, div_rsp.done, state_q == ST_DIV, "divider finished outside the divide step")
	`BMG_ASSERT_NOW(a_level_range, out_valid_q, out_q.level_percent <= LEVEL_FULL, "level above full scale")
	`BMG_ASSERT_NEXT(a_sample_idle, win_we, state_q == ST_IDLE && !out_valid_q == !$past(out_valid_q && out_stall), "sample beat disturbed the sequencer")

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the battery median gauge. Sample and read beats go
// in with random bursts and gaps while the result side stalls on its own
// pattern. A tracker keeps its own copy of the sample window and of the
// reading range, computes the upper median and the clamped percent level of
// each read, and checks every result beat in order. The range registers are
// moved between phases, extremes and inverted ranges included.
// ----------------------------------------------------------------------------
module tb;
	import bmg_pkg::*;

	localparam int WINDOW_LEN  = 20;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
	localparam int IDLE_LIMIT  = 5000;
	localparam int DRAIN_WAIT  = 600;
	localparam int SETTLE_WAIT = 4;
	localparam int PHASES      = 10;
	localparam int PHASE_BEATS = 200;

	class level_tracker;
		int       window_q [WINDOW_LEN];
		int       slot;
		int       lo_reg;
		int       hi_reg;
		bmg_out_t pending_levels [$];
		int       errors;

		function new();
			foreach (window_q[i]) window_q[i] = 0;
			slot   = 0;
			lo_reg = int'(LOW_RESET);
			hi_reg = int'(HIGH_RESET);
			errors = 0;
		endfunction

		function void set_reg(logic idx, logic [SAMPLE_W-1:0] val);
			if (idx == REG_LOW)
				lo_reg = int'(val);
			else
				hi_reg = int'(val);
		endfunction

		function int upper_median();
			int sorted [$];
			foreach (window_q[i]) sorted.push_back(window_q[i]);
			sorted.sort();
			return sorted[WINDOW_LEN / 2];
		endfunction

		function logic [LEVEL_W-1:0] scale_level(int med);
			int lvl;
			if (hi_reg <= lo_reg)
				return (med < hi_reg) ? LEVEL_NONE : LEVEL_FULL;
			if (med <= lo_reg)
				return LEVEL_NONE;
			lvl = (med - lo_reg) * int'(LEVEL_FULL) / (hi_reg - lo_reg);
			return (lvl > int'(LEVEL_FULL)) ? LEVEL_FULL : LEVEL_W'(lvl);
		endfunction

		function void take_beat(bmg_in_t beat);
			bmg_out_t want;
			int med;
			if (beat.command == CMD_SAMPLE) begin
				window_q[slot] = int'(beat.sample);
				slot = (slot + 1) % WINDOW_LEN;
			end else begin
				med = upper_median();
				want.level_percent  = scale_level(med);
				want.charge_flag    = beat.charging;
				want.median_reading = SAMPLE_W'(med);
				pending_levels.push_back(want);
			end
		endfunction

		function void check_level(bmg_out_t got);
			bmg_out_t want;
			if (pending_levels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: level %0d flag %0d median %0d",
						got.level_percent, got.charge_flag, got.median_reading);
				return;
			end
			want = pending_levels.pop_front();
			if (got.level_percent != want.level_percent
					|| got.charge_flag != want.charge_flag
					|| got.median_reading != want.median_reading) begin
				errors++;
				if (errors <= 10)
					$display("bad result: level %0d/%0d flag %0d/%0d median %0d/%0d (exp/got)",
						want.level_percent, got.level_percent,
						want.charge_flag, got.charge_flag,
						want.median_reading, got.median_reading);
			end
		endfunction

		function int pending();
			return pending_levels.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [SAMPLE_W-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	bmg_in_t             in_data;
	logic                out_valid;
	logic                out_stall;
	bmg_out_t            out_data;

	level_tracker tracker;
	int unsigned  idle_cycles;
	int unsigned  burst_left;
	int unsigned  mode_left;
	int unsigned  hold_mode;
	int unsigned  hold_left;
	logic         hold_on;
	int           cur_lo;
	int           cur_hi;

	battery_median_gauge #(.WINDOW(WINDOW_LEN)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_level(out_data);
			if (in_valid && !in_stall)
				tracker.take_beat(in_data);
			if (cfg_we)
				tracker.set_reg(cfg_index, cfg_data);
			if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("battery_median_gauge: mismatch");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (mode_left == 0) begin
			hold_mode = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 200);
		end else
			mode_left--;
		case (hold_mode)
		0: out_stall <= 1'b0;
		1: out_stall <= ($urandom_range(0, 2) == 0);
		default: begin
			if (hold_left == 0) begin
				hold_left = $urandom_range(1, 20);
				hold_on   = ~hold_on;
			end else
				hold_left--;
			out_stall <= hold_on;
		end
		endcase
	end

	task automatic send_beat(logic cmd, int val, logic chg);
		bmg_in_t beat;
		int unsigned gap;
		beat.command  = cmd;
		beat.sample   = SAMPLE_W'(val);
		beat.charging = chg;
		gap = 0;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid, wait out every read, then let the gauge settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic load_range(int lo, int hi);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOW;
		cfg_data  <= SAMPLE_W'(lo);
		@(negedge clk);
		cfg_index <= REG_HIGH;
		cfg_data  <= SAMPLE_W'(hi);
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
	endtask

	function automatic int pick_sample(int lo, int hi);
		int a, b, pad, v;
		a   = (lo < hi) ? lo : hi;
		b   = (lo < hi) ? hi : lo;
		pad = (b - a) / 4 + 8;
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4, 5: v = $urandom_range((a > pad) ? a - pad : 0,
			(b + pad > SAMPLE_MAX) ? SAMPLE_MAX : b + pad);
		6, 7: v = $urandom_range(0, SAMPLE_MAX);
		default: begin
			case ($urandom_range(0, 5))
			0: v = 0;
			1: v = SAMPLE_MAX;
			2: v = a;
			3: v = b;
			4: v = a + 1;
			default: v = b - 1;
			endcase
		end
		endcase
		if (v < 0) v = 0;
		if (v > SAMPLE_MAX) v = SAMPLE_MAX;
		return v;
	endfunction

	initial begin
		int lo_set [6] = '{0, SAMPLE_MAX, 2000, 0, SAMPLE_MAX, 1800};
		int hi_set [6] = '{SAMPLE_MAX, 0, 2000, 0, SAMPLE_MAX, 2360};
		int lo, hi;

		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_LOW;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_stall   = 1'b0;
		idle_cycles = 0;
		burst_left  = 0;
		mode_left   = 0;
		hold_mode   = 0;
		hold_left   = 0;
		hold_on     = 1'b0;
		cur_lo      = int'(LOW_RESET);
		cur_hi      = int'(HIGH_RESET);
		tracker     = new();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty window reads zero, below the low reading
		send_beat(CMD_READ, 0, 1'b1);
		send_beat(CMD_READ, SAMPLE_MAX, 1'b0);
		repeat (10) send_beat(CMD_SAMPLE, SAMPLE_MAX, 1'b0);
		send_beat(CMD_READ, 0, 1'b0);
		repeat (10) send_beat(CMD_SAMPLE, 2080, 1'b1);
		send_beat(CMD_READ, 2080, 1'b1);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 6) begin
				lo = lo_set[ph];
				hi = hi_set[ph];
			end else begin
				lo = $urandom_range(0, 4000);
				if ($urandom_range(0, 3) == 0)
					hi = $urandom_range(0, SAMPLE_MAX);
				else
					hi = lo + $urandom_range(1, 600);
				if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
			end
			load_range(lo, hi);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if ($urandom_range(0, 4) == 0)
					send_beat(CMD_READ, $urandom_range(0, SAMPLE_MAX), 1'($urandom));
				else
					send_beat(CMD_SAMPLE, pick_sample(cur_lo, cur_hi), 1'($urandom));
			end
			drain();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("battery_median_gauge: match");
		else
			$display("battery_median_gauge: mismatch");
		$finish;
	end
endmodule
